// ===== hdl/pfe_pkg.sv =====
// Shared types and constants for the Playfair digraph encryption core.
// No dependencies; imported by pfe_front, pfe_back and the top level.
package pfe_pkg;

    localparam int GRID_SIDE  = 5;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int ALPHA      = 26;
    localparam int CMD_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;

    typedef logic [4:0] letter_idx_t;
    typedef logic [4:0] cell_idx_t;

    localparam letter_idx_t IDX_I    = 5'd8;
    localparam letter_idx_t IDX_J    = 5'd9;
    localparam letter_idx_t IDX_X    = 5'd23;
    localparam letter_idx_t IDX_LAST = 5'd25;
    localparam logic [6:0]  ASCII_A_LOWER = 7'd97;

    localparam logic [1:0] FUNC_KEY    = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    typedef enum logic [1:0] {
        OP_PLACE,
        OP_FINISH,
        OP_PAIR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        letter_idx_t a;
        letter_idx_t b;
    } cmd_t;

    typedef struct packed {
        logic [6:0] first;
        logic [6:0] second;
    } pair_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_CELL,
        BK_EMIT
    } back_state_t;

endpackage

// ===== hdl/pfe_fifo.sv =====
// Small first-word-fall-through queue of flip-flops.
// Depends on nothing but its parameters; used for the command and result queues.
module pfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/pfe_front.sv =====
// Front end: accepts input transactions, folds letters, tracks key state
// and digraph pairing, and issues commands. Depends on pfe_pkg.
module pfe_front
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] func,
    input  logic [7:0] letter,
    input  logic       cmd_full,
    output logic       full,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic        key_ready_reg, key_ready_next;
    logic        pend_valid_reg, pend_valid_next;
    letter_idx_t pend_letter_reg, pend_letter_next;
    logic        accept;
    logic        is_letter;
    letter_idx_t idx;
    logic [7:0]  off_upper, off_lower;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // Fold to a letter index, j folds to i
    always_comb
    begin
        off_upper = letter - 8'd65;
        off_lower = letter - 8'd97;
        is_letter = 1'b1;
        idx       = '0;
        if (letter >= 8'd65 && letter <= 8'd90)
        begin
            idx = off_upper[4:0];
        end
        else if (letter >= 8'd97 && letter <= 8'd122)
        begin
            idx = off_lower[4:0];
        end
        else
        begin
            is_letter = 1'b0;
        end
        if (idx == IDX_J)
        begin
            idx = IDX_I;
        end
    end

    always_comb
    begin
        key_ready_next   = key_ready_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        cmd_push         = 1'b0;
        cmd.op           = OP_PLACE;
        cmd.a            = idx;
        cmd.b            = IDX_X;
        if (accept)
        begin
            case (func)
                FUNC_KEY:
                begin
                    cmd_push = !key_ready_reg && is_letter;
                end
                FUNC_FINISH:
                begin
                    if (!key_ready_reg)
                    begin
                        cmd_push        = 1'b1;
                        cmd.op          = OP_FINISH;
                        key_ready_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
                FUNC_TEXT:
                begin
                    if (key_ready_reg && is_letter)
                    begin
                        if (!pend_valid_reg)
                        begin
                            pend_valid_next  = 1'b1;
                            pend_letter_next = idx;
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_PAIR;
                            cmd.a    = pend_letter_reg;
                            // a double keeps the repeated letter pending
                            if (idx == pend_letter_reg)
                            begin
                                cmd.b = IDX_X;
                            end
                            else
                            begin
                                cmd.b           = idx;
                                pend_valid_next = 1'b0;
                            end
                        end
                    end
                end
                FUNC_END:
                begin
                    if (key_ready_reg && pend_valid_reg)
                    begin
                        cmd_push        = 1'b1;
                        cmd.op          = OP_PAIR;
                        cmd.a           = pend_letter_reg;
                        cmd.b           = IDX_X;
                        pend_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ready_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
        end
        else
        begin
            key_ready_reg   <= key_ready_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
        end
    end

endmodule

// ===== hdl/pfe_back.sv =====
// Back end: builds the key grid and substitutes digraphs.
// Holds the grid and letter position memories. Depends on pfe_pkg.
module pfe_back
    import pfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  cmd_empty,
    output logic  cmd_pop,
    input  logic  out_full,
    output logic  out_push,
    output pair_t out_data
);

    back_state_t state_reg, state_next;
    letter_idx_t sweep_reg, sweep_next;
    cell_idx_t   fill_reg, fill_next;
    logic [ALPHA-1:0] seen_reg, seen_next;

    letter_idx_t grid_mem [0:GRID_CELLS-1];
    cell_idx_t   pos_mem  [0:ALPHA-1];

    cell_idx_t   pos_a_reg, pos_b_reg;
    letter_idx_t g1_reg, g2_reg;

    logic        place_en, place_ok, dispatch;
    letter_idx_t place_idx;

    logic [8:0]  prod_a, prod_b;
    logic [2:0]  r1, c1, r2, c2;
    logic [4:0]  base_a, base_b;
    cell_idx_t   cell1, cell2;

    function automatic cell_idx_t cell_at(input logic [2:0] r, input logic [2:0] c);
        cell_at = 5'(r) * 5'(GRID_SIDE) + 5'(c);
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        wrap_inc = (v == 3'(GRID_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    // row = pos / 5 via reciprocal (exact for pos < 25), col = remainder
    always_comb
    begin
        prod_a = 9'(pos_a_reg) * 9'd13;
        prod_b = 9'(pos_b_reg) * 9'd13;
        r1     = prod_a[8:6];
        r2     = prod_b[8:6];
        base_a = 5'(r1) * 5'(GRID_SIDE);
        base_b = 5'(r2) * 5'(GRID_SIDE);
        c1     = 3'(pos_a_reg - base_a);
        c2     = 3'(pos_b_reg - base_b);
        if (r1 == r2)
        begin
            cell1 = cell_at(r1, wrap_inc(c1));
            cell2 = cell_at(r2, wrap_inc(c2));
        end
        else if (c1 == c2)
        begin
            cell1 = cell_at(wrap_inc(r1), c1);
            cell2 = cell_at(wrap_inc(r2), c2);
        end
        else
        begin
            cell1 = cell_at(r1, c2);
            cell2 = cell_at(r2, c1);
        end
    end

    assign out_data.first  = ASCII_A_LOWER + 7'(g1_reg);
    assign out_data.second = ASCII_A_LOWER + 7'(g2_reg);

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        place_en   = 1'b0;
        place_idx  = cmd.a;
        dispatch   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                dispatch = 1'b1;
            end
            BK_FILL:
            begin
                place_idx = sweep_reg;
                place_en  = (sweep_reg != IDX_J);
                if (sweep_reg == IDX_LAST)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            BK_CELL:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = BK_IDLE;
                    dispatch   = 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (dispatch && !cmd_empty)
        begin
            cmd_pop = 1'b1;
            case (cmd.op)
                OP_PLACE:
                begin
                    place_en = 1'b1;
                end
                OP_FINISH:
                begin
                    state_next = BK_FILL;
                    sweep_next = '0;
                end
                OP_PAIR:
                begin
                    state_next = BK_CELL;
                end
                default:
                begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        place_ok  = place_en && !seen_reg[place_idx] && (fill_reg < 5'(GRID_CELLS));
        seen_next = seen_reg;
        fill_next = fill_reg;
        if (place_ok)
        begin
            seen_next[place_idx] = 1'b1;
            fill_next            = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            sweep_reg <= '0;
            fill_reg  <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            fill_reg  <= fill_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_ok)
        begin
            grid_mem[fill_reg] <= place_idx;
            pos_mem[place_idx] <= fill_reg;
        end
    end

    // position read follows the queue head; used only in the cell cycle
    always_ff @(posedge clk)
    begin
        pos_a_reg <= pos_mem[cmd.a];
        pos_b_reg <= pos_mem[cmd.b];
        if (state_reg == BK_CELL)
        begin
            g1_reg <= grid_mem[cell1];
            g2_reg <= grid_mem[cell2];
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CELL |=> state_reg == BK_EMIT)
        else $error("cell lookup not followed by emit");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CELL |-> fill_reg == 5'(GRID_CELLS))
        else $error("digraph substituted before the grid is full");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(GRID_CELLS))
        else $error("grid fill count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty && (state_reg == BK_IDLE || state_reg == BK_EMIT))
        else $error("command taken outside dispatch");
`endif

endmodule

// ===== hdl/playfair_digraph_encrypt_core.sv =====
// Top level of the Playfair digraph encryption core.
// Instantiates pfe_front, pfe_back and two pfe_fifo queues; depends on pfe_pkg.
//
// Input transactions enter through a front end that takes one per cycle while
// its command queue has room; keyword letters, finish key and text letters are
// classified there and passed as commands to the back end. A new keyword letter
// is placed in the grid as the back end takes it. Finish key runs a sweep
// over the alphabet while later commands wait in the queue. A completed
// digraph goes through a letter position read, then a grid read, and yields
// two cipher letters, one per cycle on the result side while the reader pops;
// the back end takes the next command as it pushes each result. Text before
// finish key, and non-letters, produce nothing.
module playfair_digraph_encrypt_core
    import pfe_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = CMD_DEPTH,
    parameter int OUT_QUEUE_DEPTH = OUT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] func,
    input  logic [7:0] letter,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] cipher_letter,
    output logic       pair_last
);

    cmd_t  fe_cmd, q_cmd;
    logic  fe_cmd_push, cmd_full, cmd_empty, cmd_pop;
    pair_t be_pair, q_pair;
    logic  be_push, out_full, out_empty, out_pop;
    logic  half_reg, half_next;

    pfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .func     (func),
        .letter   (letter),
        .cmd_full (cmd_full),
        .full     (full),
        .cmd_push (fe_cmd_push),
        .cmd      (fe_cmd)
    );

    pfe_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (fe_cmd_push),
        .wdata (fe_cmd),
        .rd_en (cmd_pop),
        .rdata (q_cmd),
        .full  (cmd_full),
        .empty (cmd_empty)
    );

    pfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (be_push),
        .out_data  (be_pair)
    );

    pfe_fifo #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (be_push),
        .wdata (be_pair),
        .rd_en (out_pop),
        .rdata (q_pair),
        .full  (out_full),
        .empty (out_empty)
    );

    // each queued digraph is handed out as two transactions
    assign empty         = out_empty;
    assign cipher_letter = half_reg ? q_pair.second : q_pair.first;
    assign pair_last     = half_reg;
    assign out_pop       = pop && !out_empty && half_reg;

    always_comb
    begin
        half_next = half_reg;
        if (pop && !out_empty)
        begin
            half_next = !half_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
        end
    end

endmodule
